@@ rtl/dor_pkg.sv @@
// Shared types and constants for the directional overcurrent relay.
`timescale 1ns / 1ps
package dor_pkg;

  // Lane geometry: fields are packed as four 16-bit lanes.
  localparam int MAX_PHASES = 4;
  localparam int LANE_W     = 16;
  localparam int TIMER_W    = 32;
  localparam int DT_W       = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_LEVELS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POL_VOLTAGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_ANGLE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATE_DELAY    = 3'd6;

  // Direction modes; the unused code behaves as reverse
  localparam logic [1:0] DIR_NONDIRECTIONAL = 2'd0;
  localparam logic [1:0] DIR_FORWARD        = 2'd1;
  localparam logic [1:0] DIR_REVERSE        = 2'd2;

  // Half turn in binary angle units
  localparam logic [LANE_W-1:0] HALF_TURN = 16'h8000;

  // Decoupling queue between classifier and timer stage
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Per-frame classification handed from front to back
  typedef struct packed {
    logic [MAX_PHASES-1:0] enable;   // phase evaluated this frame
    logic [MAX_PHASES-1:0] start;    // above pickup with valid direction
    logic [DT_W-1:0]       elapsed_us;
  } lane_class_t;

endpackage

@@ rtl/dor_front.sv @@
// Front end: accepts measurement frames and classifies each phase lane.
`timescale 1ns / 1ps
module dor_front
  import dor_pkg::*;
#(
  parameter int NUM_PHASES = 4
) (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [MAX_PHASES*LANE_W-1:0] current_mags,
  input  logic [MAX_PHASES*LANE_W-1:0] current_angles,
  input  logic [MAX_PHASES*LANE_W-1:0] voltage_mags,
  input  logic [MAX_PHASES*LANE_W-1:0] voltage_angles,
  input  logic [DT_W-1:0]              elapsed_us,
  input  logic [1:0]                   direction_mode,
  input  logic [MAX_PHASES-1:0]        phase_enable,
  input  logic [MAX_PHASES*LANE_W-1:0] pickup_levels,
  input  logic [LANE_W-1:0]            min_polarizing_voltage,
  input  logic signed [LANE_W-1:0]     relay_angle,
  input  logic [LANE_W-1:0]            window_half,
  input  logic                         q_full,
  output logic                         q_push,
  output lane_class_t                  q_data
);

  logic [LANE_W-1:0]     ref_angle;
  logic [MAX_PHASES-1:0] lane_en;
  logic [MAX_PHASES-1:0] lane_start;

  // Handshake into the queue
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Reference angle: relay angle, shifted a half turn unless forward
  assign ref_angle = (direction_mode == DIR_FORWARD) ? $unsigned(relay_angle)
                                                     : $unsigned(relay_angle) + HALF_TURN;

  // Per-lane pickup and direction checks
  for (genvar p = 0; p < MAX_PHASES; p++) begin : g_lane
    if (p < NUM_PHASES) begin : g_active
      logic [LANE_W-1:0] cur;
      logic [LANE_W-1:0] pick;
      logic [LANE_W-1:0] rel;
      logic [LANE_W-1:0] diff;
      logic [LANE_W:0]   diff_abs;
      logic              above;
      logic              dir_ok;

      assign cur  = current_mags[p*LANE_W +: LANE_W];
      assign pick = pickup_levels[p*LANE_W +: LANE_W];
      assign rel  = current_angles[p*LANE_W +: LANE_W] - voltage_angles[p*LANE_W +: LANE_W];
      assign diff = rel - ref_angle;

      // Magnitude of the signed angle error, up to a half turn
      assign diff_abs = diff[LANE_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};

      assign above  = (pick != '0) && (cur >= pick);
      assign dir_ok = (direction_mode == DIR_NONDIRECTIONAL) ||
                      ((voltage_mags[p*LANE_W +: LANE_W] >= min_polarizing_voltage) &&
                       (diff_abs <= {1'b0, window_half}));

      assign lane_en[p]    = phase_enable[p];
      assign lane_start[p] = phase_enable[p] && above && dir_ok;
    end else begin : g_idle
      assign lane_en[p]    = 1'b0;
      assign lane_start[p] = 1'b0;
    end
  end

  assign q_data.enable     = lane_en;
  assign q_data.start      = lane_start;
  assign q_data.elapsed_us = elapsed_us;

endmodule

@@ rtl/dor_queue.sv @@
// Short FIFO that decouples the classifier from the timer stage.
`timescale 1ns / 1ps
module dor_queue
  import dor_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lane_class_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output lane_class_t pop_data
);

  lane_class_t       entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Pointer and occupancy tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/dor_back.sv @@
// Back end: phase timers, trip decision and the output register.
`timescale 1ns / 1ps
module dor_back
  import dor_pkg::*;
#(
  parameter int NUM_PHASES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_not_empty,
  output logic                  q_pop,
  input  lane_class_t           q_data,
  input  logic [TIMER_W-1:0]    operate_delay_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MAX_PHASES-1:0] start_flags,
  output logic [MAX_PHASES-1:0] trip_flags
);

  logic [TIMER_W-1:0]    phase_timer      [NUM_PHASES];
  logic [TIMER_W-1:0]    phase_timer_next [NUM_PHASES];
  logic [MAX_PHASES-1:0] trip_next;
  logic                  delay_zero;

  // Take a transaction whenever the output register is free or draining
  assign q_pop      = q_not_empty && (!out_valid || out_ready);
  assign delay_zero = (operate_delay_us == '0);

  // Timer update per lane
  always_comb begin
    logic [TIMER_W:0] sum;
    logic [TIMER_W-1:0] sat;
    trip_next = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      sum = {1'b0, phase_timer[p]} + {{(TIMER_W+1-DT_W){1'b0}}, q_data.elapsed_us};
      sat = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
      phase_timer_next[p] = phase_timer[p];
      if (q_data.enable[p]) begin
        if (!q_data.start[p]) begin
          phase_timer_next[p] = '0;
        end else if (delay_zero) begin
          trip_next[p] = 1'b1;
        end else begin
          phase_timer_next[p] = sat;
          trip_next[p] = (sat >= operate_delay_us);
        end
      end
    end
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PHASES; p++) phase_timer[p] <= '0;
    end else if (q_pop) begin
      for (int p = 0; p < NUM_PHASES; p++) phase_timer[p] <= phase_timer_next[p];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      start_flags <= q_data.start;
      trip_flags  <= trip_next;
    end
  end

endmodule

@@ rtl/directional_overcurrent_relay.sv @@
// Top level of the directional overcurrent relay: config registers and pipeline.
// A frame accepted at the input is written into the queue, then its result is taken into the output register.
// Throughput: one frame per cycle while out_ready is held high; the timer add/compare lane is combinational.
// The front classifies frames into a two-entry queue; the back drains it independently.
// Reset: synchronous, clears all config registers, phase timers, the queue and out_valid.
`timescale 1ns / 1ps
module directional_overcurrent_relay
  import dor_pkg::*;
#(
  parameter int NUM_PHASES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  // Frame input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [MAX_PHASES*LANE_W-1:0] current_mags,
  input  logic [MAX_PHASES*LANE_W-1:0] current_angles,
  input  logic [MAX_PHASES*LANE_W-1:0] voltage_mags,
  input  logic [MAX_PHASES*LANE_W-1:0] voltage_angles,
  input  logic [DT_W-1:0]              elapsed_us,
  // Result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [MAX_PHASES-1:0]        start_flags,
  output logic [MAX_PHASES-1:0]        trip_flags,
  // Configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  logic [1:0]                   direction_mode;
  logic [MAX_PHASES-1:0]        phase_enable;
  logic [MAX_PHASES*LANE_W-1:0] pickup_levels;
  logic [LANE_W-1:0]            min_polarizing_voltage;
  logic signed [LANE_W-1:0]     relay_angle;
  logic [LANE_W-1:0]            window_half;
  logic [TIMER_W-1:0]           operate_delay_us;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  lane_class_t q_in;
  lane_class_t q_out;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      direction_mode         <= '0;
      phase_enable           <= '0;
      pickup_levels          <= '0;
      min_polarizing_voltage <= '0;
      relay_angle            <= '0;
      window_half            <= '0;
      operate_delay_us       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIRECTION_MODE:  direction_mode         <= cfg_data[1:0];
        CFG_PHASE_ENABLE:    phase_enable           <= cfg_data[MAX_PHASES-1:0];
        CFG_PICKUP_LEVELS:   pickup_levels          <= cfg_data[MAX_PHASES*LANE_W-1:0];
        CFG_MIN_POL_VOLTAGE: min_polarizing_voltage <= cfg_data[LANE_W-1:0];
        CFG_RELAY_ANGLE:     relay_angle            <= $signed(cfg_data[LANE_W-1:0]);
        CFG_WINDOW_HALF:     window_half            <= cfg_data[LANE_W-1:0];
        CFG_OPERATE_DELAY:   operate_delay_us       <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Classifier
  dor_front #(
    .NUM_PHASES(NUM_PHASES)
  ) u_front (
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .current_mags          (current_mags),
    .current_angles        (current_angles),
    .voltage_mags          (voltage_mags),
    .voltage_angles        (voltage_angles),
    .elapsed_us            (elapsed_us),
    .direction_mode        (direction_mode),
    .phase_enable          (phase_enable),
    .pickup_levels         (pickup_levels),
    .min_polarizing_voltage(min_polarizing_voltage),
    .relay_angle           (relay_angle),
    .window_half           (window_half),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_data                (q_in)
  );

  // Decoupling queue
  dor_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_out)
  );

  // Timers and result register
  dor_back #(
    .NUM_PHASES(NUM_PHASES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_pop           (q_pop),
    .q_data          (q_out),
    .operate_delay_us(operate_delay_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .start_flags     (start_flags),
    .trip_flags      (trip_flags)
  );

endmodule
